[hdl/qgcc_pkg.sv]
// Shared types, character codes and helper functions for the quiet-gated charge control.
package qgcc_pkg;

  // Request kinds on the input channel (code 3 is unused)
  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_SAMPLE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    RPT_NONE   = 2'd0,
    RPT_STATUS = 2'd1,
    RPT_MOVE   = 2'd2
  } report_kind_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_LIMIT  = 2'd1,
    CMD_QUIET  = 2'd2,
    CMD_REJECT = 2'd3
  } cmd_result_t;

  localparam int LINE_BUFFER_DEF = 20;
  localparam int STORE_DEPTH     = 13;
  localparam int LEN_W           = 5;
  localparam int LEN_MAX         = 31;

  localparam int ACCEL_RAW_W = 16;
  localparam int ACCEL_W     = 14;
  localparam int VOLT_W      = 12;
  localparam int LIMIT_W     = 14;
  localparam int QTIME_W     = 7;
  localparam int QSEC_W      = 8;

  // x / 7 == (x * 74899) >> 19 for every 16-bit x
  localparam int ACCEL_SHIFT = 19;
  localparam logic [16:0] ACCEL_RECIP = 17'd74899;
  localparam int PROD_W = ACCEL_RAW_W + 17;

  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_S_LO = 8'h73;
  localparam logic [7:0] CHAR_S_UP = 8'h53;

  localparam logic [39:0] KW_BATT  = "batt=";
  localparam logic [47:0] KW_QUIET = "quiet=";

  localparam int LEN_STATUS = 1;
  localparam int LEN_BATT   = 9;
  localparam int LEN_QUIET  = 13;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Digits are checked separately; the low nibble of '0'..'9' is the value
  function automatic logic [13:0] dec4(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
    return 14'(a[3:0]) * 14'd1000 + 14'(b[3:0]) * 14'd100 +
           14'(c[3:0]) * 14'd10 + 14'(d[3:0]);
  endfunction

  function automatic logic [6:0] dec2(input logic [7:0] a, input logic [7:0] b);
    return 7'(a[3:0]) * 7'd10 + 7'(b[3:0]);
  endfunction

endpackage

[hdl/quiet_gated_charge_control.sv]
// Quiet-gated charge control: command line parser, quiet timer and charge decision.
//
// Takes one request per clock: a command byte, a one-second tick or a sample pair, and
// answers every request with exactly one result. An input register is followed by one
// pass of parsing, divide-by-7 and compare logic into the result register; a stalled
// result blocks the input only once both registers are full. Command lines end
// at CR or LF; "s"/"S" asks for a status report, "batt=dddd" sets the voltage limit and
// "quiet=yyyy?zz" sets the movement threshold and quiet time. LINE_BUFFER sets how many
// characters of a line are counted (LINE_BUFFER-1, at most 31); only 13 are stored.
module quiet_gated_charge_control #(
  parameter int LINE_BUFFER = qgcc_pkg::LINE_BUFFER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic [15:0] in_accel_raw,
  input  logic [11:0] in_voltage_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_charging,
  output logic [1:0]  out_report_kind,
  output logic [11:0] out_report_voltage,
  output logic [13:0] out_report_accel,
  output logic [1:0]  out_command_result
);

  localparam int LenCapInt = (LINE_BUFFER - 1 < qgcc_pkg::LEN_MAX) ?
                             (LINE_BUFFER - 1) : qgcc_pkg::LEN_MAX;
  localparam logic [qgcc_pkg::LEN_W-1:0] LEN_CAP = qgcc_pkg::LEN_W'(LenCapInt);

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_action_r;
  logic [7:0]  s1_byte_r;
  logic [15:0] s1_accel_r;
  logic [11:0] s1_volt_r;

  // block state
  logic                          charging_r, charging_nxt;
  logic [qgcc_pkg::QSEC_W-1:0]   qsec_r, qsec_nxt;
  logic [qgcc_pkg::LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [qgcc_pkg::QTIME_W-1:0]  qtime_r, qtime_nxt;
  logic [qgcc_pkg::ACCEL_W-1:0]  thresh_r, thresh_nxt;
  logic [qgcc_pkg::LEN_W-1:0]    line_len_r, line_len_nxt;
  logic [qgcc_pkg::VOLT_W-1:0]   last_volt_r, last_volt_nxt;
  logic [qgcc_pkg::ACCEL_W-1:0]  last_accel_r, last_accel_nxt;
  logic [7:0]                    line_chars_r [qgcc_pkg::STORE_DEPTH];
  logic                          char_wr;

  // result register
  logic        out_valid_r;
  logic        out_charging_r;
  logic [1:0]  out_kind_r, kind_nxt;
  logic [11:0] out_volt_r, rep_volt_nxt;
  logic [13:0] out_accel_r, rep_accel_nxt;
  logic [1:0]  out_result_r, result_nxt;

  logic                          s1_adv;
  logic [qgcc_pkg::PROD_W-1:0]   prod;
  logic [qgcc_pkg::ACCEL_W-1:0]  scaled;
  logic                          is_status, is_batt, is_quiet;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_rx_byte;
      s1_accel_r  <= in_accel_raw;
      s1_volt_r   <= in_voltage_sample;
    end
  end

  assign prod   = qgcc_pkg::PROD_W'(s1_accel_r) * qgcc_pkg::PROD_W'(qgcc_pkg::ACCEL_RECIP);
  assign scaled = prod[qgcc_pkg::ACCEL_SHIFT +: qgcc_pkg::ACCEL_W];

  assign is_status = (line_len_r == qgcc_pkg::LEN_W'(qgcc_pkg::LEN_STATUS)) &&
                     ((line_chars_r[0] == qgcc_pkg::CHAR_S_LO) ||
                      (line_chars_r[0] == qgcc_pkg::CHAR_S_UP));

  assign is_batt = (line_len_r == qgcc_pkg::LEN_W'(qgcc_pkg::LEN_BATT)) &&
                   ({line_chars_r[0], line_chars_r[1], line_chars_r[2], line_chars_r[3],
                     line_chars_r[4]} == qgcc_pkg::KW_BATT) &&
                   qgcc_pkg::is_digit(line_chars_r[5]) && qgcc_pkg::is_digit(line_chars_r[6]) &&
                   qgcc_pkg::is_digit(line_chars_r[7]) && qgcc_pkg::is_digit(line_chars_r[8]);

  assign is_quiet = (line_len_r == qgcc_pkg::LEN_W'(qgcc_pkg::LEN_QUIET)) &&
                    ({line_chars_r[0], line_chars_r[1], line_chars_r[2], line_chars_r[3],
                      line_chars_r[4], line_chars_r[5]} == qgcc_pkg::KW_QUIET) &&
                    qgcc_pkg::is_digit(line_chars_r[6]) && qgcc_pkg::is_digit(line_chars_r[7]) &&
                    qgcc_pkg::is_digit(line_chars_r[8]) && qgcc_pkg::is_digit(line_chars_r[9]) &&
                    qgcc_pkg::is_digit(line_chars_r[11]) &&
                    qgcc_pkg::is_digit(line_chars_r[12]);

  always_comb begin
    charging_nxt   = charging_r;
    qsec_nxt       = qsec_r;
    limit_nxt      = limit_r;
    qtime_nxt      = qtime_r;
    thresh_nxt     = thresh_r;
    line_len_nxt   = line_len_r;
    last_volt_nxt  = last_volt_r;
    last_accel_nxt = last_accel_r;
    char_wr        = 1'b0;
    kind_nxt       = qgcc_pkg::RPT_NONE;
    rep_volt_nxt   = '0;
    rep_accel_nxt  = '0;
    result_nxt     = qgcc_pkg::CMD_NONE;
    case (s1_action_r)
      qgcc_pkg::ACT_BYTE: begin
        if (s1_byte_r == qgcc_pkg::CHAR_CR || s1_byte_r == qgcc_pkg::CHAR_LF) begin
          if (is_status) begin
            kind_nxt      = qgcc_pkg::RPT_STATUS;
            rep_volt_nxt  = last_volt_r;
            rep_accel_nxt = last_accel_r;
          end else if (is_batt) begin
            limit_nxt  = qgcc_pkg::dec4(line_chars_r[5], line_chars_r[6],
                                        line_chars_r[7], line_chars_r[8]);
            result_nxt = qgcc_pkg::CMD_LIMIT;
          end else if (is_quiet) begin
            thresh_nxt = qgcc_pkg::dec4(line_chars_r[6], line_chars_r[7],
                                        line_chars_r[8], line_chars_r[9]);
            qtime_nxt  = qgcc_pkg::dec2(line_chars_r[11], line_chars_r[12]);
            qsec_nxt   = '0;
            result_nxt = qgcc_pkg::CMD_QUIET;
          end else begin
            result_nxt = qgcc_pkg::CMD_REJECT;
          end
          line_len_nxt = '0;
        end else if (line_len_r < LEN_CAP) begin
          char_wr      = line_len_r < qgcc_pkg::LEN_W'(qgcc_pkg::STORE_DEPTH);
          line_len_nxt = line_len_r + 1'b1;
        end
      end
      qgcc_pkg::ACT_TICK: begin
        if (qsec_r != '1) begin
          qsec_nxt = qsec_r + 1'b1;
        end
      end
      qgcc_pkg::ACT_SAMPLE: begin
        last_volt_nxt  = s1_volt_r;
        last_accel_nxt = scaled;
        if (limit_r > qgcc_pkg::LIMIT_W'(s1_volt_r)) begin
          if (scaled > thresh_r) begin
            qsec_nxt      = '0;
            kind_nxt      = qgcc_pkg::RPT_MOVE;
            rep_volt_nxt  = s1_volt_r;
            rep_accel_nxt = scaled;
          end
          charging_nxt = qsec_nxt > qgcc_pkg::QSEC_W'(qtime_r);
        end else begin
          charging_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charging_r   <= 1'b0;
      qsec_r       <= '0;
      limit_r      <= '0;
      qtime_r      <= '0;
      thresh_r     <= '0;
      line_len_r   <= '0;
      last_volt_r  <= '0;
      last_accel_r <= '0;
    end else if (s1_valid_r && s1_adv) begin
      charging_r   <= charging_nxt;
      qsec_r       <= qsec_nxt;
      limit_r      <= limit_nxt;
      qtime_r      <= qtime_nxt;
      thresh_r     <= thresh_nxt;
      line_len_r   <= line_len_nxt;
      last_volt_r  <= last_volt_nxt;
      last_accel_r <= last_accel_nxt;
    end
  end

  // line store, written at the current length
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv && char_wr) begin
      line_chars_r[line_len_r[3:0]] <= s1_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_charging_r <= charging_nxt;
      out_kind_r     <= kind_nxt;
      out_volt_r     <= rep_volt_nxt;
      out_accel_r    <= rep_accel_nxt;
      out_result_r   <= result_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_charging       = out_charging_r;
  assign out_report_kind    = out_kind_r;
  assign out_report_voltage = out_volt_r;
  assign out_report_accel   = out_accel_r;
  assign out_command_result = out_result_r;

  a_move_stops_charge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == qgcc_pkg::RPT_MOVE) |-> !out_charging_r)
    else $error("movement report with charging enabled");

  a_report_or_command: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_result_r != qgcc_pkg::CMD_NONE) |-> (out_kind_r == qgcc_pkg::RPT_NONE))
    else $error("report and command result in one request");

  a_line_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= LEN_CAP)
    else $error("line length beyond cap");

  a_quiet_timer_step: assert property (@(posedge clk) disable iff (!rst_n)
    (qsec_r != $past(qsec_r)) |-> (qsec_r == '0) || (qsec_r == $past(qsec_r) + 1'b1))
    else $error("quiet timer jumped");

endmodule
